// ===== hw/rtl/crbm_pkg.sv =====
package crbm_pkg;

    // Mapper kinds as read from the cartridge header.
    typedef enum logic [1:0] {
        MAP_NONE = 2'd0,
        MAP_MBC1 = 2'd1,
        MAP_MBC3 = 2'd2,
        MAP_MBC5 = 2'd3
    } mapper_kind_t;

    // Bus access kinds.
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam int ADDR_BITS      = 15;
    localparam int DATA_BITS      = 8;
    localparam int WINDOW_BITS    = 14;
    localparam int ROM_ADDR_BITS  = 23;
    localparam int FULL_BANK_BITS = 9;

    // Register regions, selected by the top address bits.
    localparam logic [1:0] MBC1_RGN_BANK_LO = 2'd1;
    localparam logic [1:0] MBC1_RGN_BANK_HI = 2'd2;
    localparam logic [1:0] MBC1_RGN_MODE    = 2'd3;
    localparam logic [1:0] MBC3_RGN_BANK    = 2'd1;
    localparam logic [2:0] MBC5_RGN_BANK_LO = 3'd2;
    localparam logic [2:0] MBC5_RGN_BANK_HI = 3'd3;

    typedef struct packed {
        logic                   kind;
        logic [ADDR_BITS-1:0]   bus_address;
        logic [DATA_BITS-1:0]   write_data;
    } req_t;

    typedef struct packed {
        logic [ROM_ADDR_BITS-1:0] rom_address;
    } rsp_t;

endpackage

// ===== hw/rtl/crbm_stream_if.sv =====
interface crbm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== hw/rtl/cartridge_rom_bank_mapper_core.sv =====
// Cartridge ROM bank mapper. Each request is one CPU access to cartridge space:
// a write updates the bank registers of the configured mapper (MBC1, MBC3 or
// MBC5) and gives no result, while a read gives the physical ROM byte address.
// One request is accepted every cycle unless the request stage is blocked; a read
// passes through the request stage and then the result register, and a later
// request always sees the bank left by earlier writes.
// A stalled result only holds up the request stage when that stage holds a read.
// mapper_kind must be written only while no request is in flight.
module cartridge_rom_bank_mapper_core #(
    parameter int BANK_BITS = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    crbm_stream_if.sink         req,
    crbm_stream_if.source       rsp
);

    localparam int FullBits = crbm_pkg::FULL_BANK_BITS;

    crbm_pkg::mapper_kind_t     mapper_kind_reg;
    logic [BANK_BITS-1:0]       rom_bank_reg;
    logic [BANK_BITS-1:0]       rom_bank_next;
    logic                       banking_mode_reg;
    logic                       banking_mode_next;

    logic                       s1_valid_reg;
    crbm_pkg::req_t             s1_item_reg;
    logic                       s1_go;
    logic                       s1_is_read;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    crbm_pkg::rsp_t             rsp_payload_reg;
    crbm_pkg::rsp_t             rsp_payload_next;

    logic [FullBits-1:0]        bank_full;
    logic [FullBits-1:0]        bank_full_next;
    logic [4:0]                 mbc1_low;
    logic [6:0]                 mbc3_bank;

    assign s1_is_read = (s1_item_reg.kind == crbm_pkg::ACC_READ);
    // Writes leave the stage at once; reads need room in the result register.
    assign s1_go      = s1_valid_reg && (!s1_is_read || !rsp_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_go;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    assign bank_full = FullBits'(rom_bank_reg);

    always_comb
    begin
        mbc1_low  = s1_item_reg.write_data[4:0];
        if (mbc1_low == 5'd0)
        begin
            mbc1_low = 5'd1;
        end
        mbc3_bank = s1_item_reg.write_data[6:0];
        if (mbc3_bank == 7'd0)
        begin
            mbc3_bank = 7'd1;
        end

        bank_full_next    = bank_full;
        banking_mode_next = banking_mode_reg;
        if (s1_go && !s1_is_read)
        begin
            case (mapper_kind_reg)
                crbm_pkg::MAP_MBC1:
                begin
                    case (s1_item_reg.bus_address[14:13])
                        crbm_pkg::MBC1_RGN_BANK_LO:
                            bank_full_next = {2'b00, bank_full[6:5], mbc1_low};
                        crbm_pkg::MBC1_RGN_BANK_HI:
                        begin
                            // The upper bank bits follow only in mode 0.
                            if (!banking_mode_reg)
                            begin
                                bank_full_next = {2'b00, s1_item_reg.write_data[1:0],
                                                  bank_full[4:0]};
                            end
                        end
                        crbm_pkg::MBC1_RGN_MODE:
                            banking_mode_next = s1_item_reg.write_data[0];
                        default:
                            bank_full_next = bank_full;
                    endcase
                end
                crbm_pkg::MAP_MBC3:
                begin
                    if (s1_item_reg.bus_address[14:13] == crbm_pkg::MBC3_RGN_BANK)
                    begin
                        bank_full_next = {2'b00, mbc3_bank};
                    end
                end
                crbm_pkg::MAP_MBC5:
                begin
                    case (s1_item_reg.bus_address[14:12])
                        crbm_pkg::MBC5_RGN_BANK_LO:
                            bank_full_next = {bank_full[8], s1_item_reg.write_data};
                        crbm_pkg::MBC5_RGN_BANK_HI:
                            bank_full_next = {s1_item_reg.write_data[0], bank_full[7:0]};
                        default:
                            bank_full_next = bank_full;
                    endcase
                end
                default:
                    bank_full_next = bank_full;
            endcase
        end
        rom_bank_next = bank_full_next[BANK_BITS-1:0];
    end

    always_comb
    begin
        rsp_payload_next = rsp_payload_reg;
        rsp_valid_next   = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (s1_go && s1_is_read)
        begin
            rsp_valid_next = 1'b1;
            if (!s1_item_reg.bus_address[crbm_pkg::WINDOW_BITS])
            begin
                rsp_payload_next.rom_address =
                    crbm_pkg::ROM_ADDR_BITS'(s1_item_reg.bus_address);
            end
            else
            begin
                rsp_payload_next.rom_address =
                    {bank_full, s1_item_reg.bus_address[crbm_pkg::WINDOW_BITS-1:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_kind_reg  <= crbm_pkg::MAP_NONE;
            rom_bank_reg     <= BANK_BITS'(1);
            banking_mode_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mapper_kind_reg <= crbm_pkg::mapper_kind_t'(cfg_wdata);
            end
            rom_bank_reg     <= rom_bank_next;
            banking_mode_reg <= banking_mode_next;
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= req.payload;
        end
        rsp_payload_reg <= rsp_payload_next;
    end

    // A result only ever comes from a read leaving the request stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(s1_valid_reg && s1_is_read))
        else $error("result raised without a read in the request stage");

    // Without a mapper, writes never move the bank.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && !s1_is_read && mapper_kind_reg == crbm_pkg::MAP_NONE)
            |=> $stable(rom_bank_reg))
        else $error("bank changed by a write with no mapper");

    // A blocked read stays in the request stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("blocked request lost from the request stage");

endmodule
